@@ design/mpf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_pkg
// Shared types and constants of the multilevel priority fifo.
// ----------------------------------------------------------------------------
package mpf_pkg;

    localparam int MAX_LEVELS_DEF = 32;
    localparam int FIFO_DEPTH_DEF = 16;
    localparam int ITEM_WIDTH_DEF = 32;

    localparam int CMD_W     = 2;
    localparam int LEVEL_W   = 5;
    localparam int DATA_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 6;

    // level + item_data, padded to whole bytes
    localparam int S_TDATA_W = ((LEVEL_W + DATA_W + 7) / 8) * 8;
    // item_out + served_level, padded to whole bytes
    localparam int M_TDATA_W = ((DATA_W + LEVEL_W + 7) / 8) * 8;
    localparam int S_PAD_W   = S_TDATA_W - LEVEL_W - DATA_W;
    localparam int M_PAD_W   = M_TDATA_W - DATA_W - LEVEL_W;

    localparam int CHUNK_W   = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_PEEK = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_SCAN,
        S_READ,
        S_RESP
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } store_ctrl_t;

endpackage

@@ design/mpf_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_store
// Single-port item memory shared by all levels, registered read data.
// ----------------------------------------------------------------------------
module mpf_store #(
    parameter int ADDR_W = 9,
    parameter int DEPTH  = 512,
    parameter int WORD_W = 32
) (
    input  logic                  aclk,
    input  mpf_pkg::store_ctrl_t  ctrl,
    input  logic [ADDR_W-1:0]     addr,
    input  logic [WORD_W-1:0]     wdata,
    output logic [WORD_W-1:0]     rdata
);
    import mpf_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[addr] <= wdata;
        end
        if (ctrl.rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/multilevel_priority_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_priority_fifo
// Priority queue of up to MAX_LEVELS fifo levels with a non-empty bitmap.
// ----------------------------------------------------------------------------
// Usage: one command beat enters on the s_ channel (push, pop or peek) and
// exactly one result beat leaves on the m_ channel. The block works on one
// command at a time; s_tready is high only while it is idle.
// Push: S_PUSH checks the level and writes the store as it registers the
// result. Pop and peek: a shared 8-bit priority encoder walks the bitmap
// from the top, one 8-level chunk per cycle, then S_READ reads the item
// memory and S_RESP registers the result. A new command is taken only once
// the result of the last one is registered.
// Results sit in an output register; while the receiver stalls the next
// command is still accepted and its result waits until the register frees.
// Reset empties every level (pointers, counts and bitmap clear at once) and
// sets num_levels to MAX_LEVELS. The item memory is not cleared; entries are
// only ever read after they have been written.
// cfg_we writes num_levels; values of 0 or above MAX_LEVELS are dropped.
// ----------------------------------------------------------------------------
module multilevel_priority_fifo #(
    parameter int MAX_LEVELS = mpf_pkg::MAX_LEVELS_DEF,
    parameter int FIFO_DEPTH = mpf_pkg::FIFO_DEPTH_DEF,
    parameter int ITEM_WIDTH = mpf_pkg::ITEM_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // level [4:0], item_data [36:5], zero fill above
    input  logic [mpf_pkg::S_TDATA_W-1:0]  s_tdata,
    // cmd [1:0]
    input  logic [mpf_pkg::CMD_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // item_out [31:0], served_level [36:32], zero fill above
    output logic [mpf_pkg::M_TDATA_W-1:0]  m_tdata,
    // status [1:0]
    output logic [mpf_pkg::STATUS_W-1:0]   m_tuser,
    input  logic                           cfg_we,
    input  logic [mpf_pkg::CFG_W-1:0]      cfg_wdata
);
    import mpf_pkg::*;

    localparam int LVL_W     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int PTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
    localparam int STORE_W   = (ITEM_WIDTH < DATA_W) ? ITEM_WIDTH : DATA_W;
    localparam int NCHUNK    = (MAX_LEVELS + CHUNK_W - 1) / CHUNK_W;
    localparam int CH_W      = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PAD_W     = NCHUNK * CHUNK_W;
    localparam int ENC_W     = $clog2(CHUNK_W);
    localparam int SCAN_W    = CH_W + ENC_W;
    localparam int ADDR_W    = LVL_W + PTR_W;
    localparam int MEM_DEPTH = MAX_LEVELS * (1 << PTR_W);

    // control state
    state_t              state_reg, state_next;
    logic                is_pop_reg, is_pop_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic [STORE_W-1:0]  data_reg, data_next;
    logic [CH_W-1:0]     chunk_reg, chunk_next;
    logic [LVL_W-1:0]    sel_reg, sel_next;
    status_t             status_reg, status_next;
    logic [CFG_W-1:0]    num_levels_reg;

    // per-level queue state
    logic [PTR_W-1:0]      head_reg  [MAX_LEVELS];
    logic [PTR_W-1:0]      tail_reg  [MAX_LEVELS];
    logic [CNT_W-1:0]      count_reg [MAX_LEVELS];
    logic [MAX_LEVELS-1:0] mask_reg;

    // output register
    logic                m_valid_reg;
    status_t             m_status_reg;
    logic [DATA_W-1:0]   m_item_reg;
    logic [LEVEL_W-1:0]  m_served_reg;

    logic                out_free;
    logic                deliver;
    status_t             res_status;
    logic [DATA_W-1:0]   res_item;
    logic [LEVEL_W-1:0]  res_served;
    logic                push_commit;
    logic                pop_commit;

    logic                push_in_range;
    logic [LVL_W-1:0]    push_lvl;
    logic                push_full;
    logic [PAD_W-1:0]    usable;
    logic [CHUNK_W-1:0]  chunk_bits;
    logic                chunk_hit;
    logic [ENC_W-1:0]    enc;
    logic [SCAN_W-1:0]   scan_lvl;

    store_ctrl_t         st_ctrl;
    logic [ADDR_W-1:0]   st_addr;
    logic [STORE_W-1:0]  st_rdata;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    // push check
    assign push_in_range = ({1'b0, level_reg} < num_levels_reg)
                        && ({1'b0, level_reg} < CFG_W'(MAX_LEVELS));
    assign push_lvl  = level_reg[LVL_W-1:0];
    assign push_full = (count_reg[push_lvl] == CNT_W'(FIFO_DEPTH));

    // levels that may be served, padded to whole chunks
    always_comb begin
        usable = '0;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            usable[i] = mask_reg[i] && (CFG_W'(i) < num_levels_reg);
        end
    end

    // shared chunk encoder: highest set bit of the chunk under scan
    assign chunk_bits = usable[{chunk_reg, ENC_W'(0)} +: CHUNK_W];
    assign chunk_hit  = |chunk_bits;

    always_comb begin
        enc = '0;
        for (int j = 0; j < CHUNK_W; j++) begin
            if (chunk_bits[j]) begin
                enc = ENC_W'(j);
            end
        end
    end

    assign scan_lvl = {chunk_reg, enc};

    always_comb begin
        state_next  = state_reg;
        is_pop_next = is_pop_reg;
        level_next  = level_reg;
        data_next   = data_reg;
        chunk_next  = chunk_reg;
        sel_next    = sel_reg;
        status_next = status_reg;
        st_ctrl     = '0;
        st_addr     = {sel_reg, head_reg[sel_reg]};
        deliver     = 1'b0;
        res_status  = status_reg;
        res_item    = '0;
        res_served  = '0;
        push_commit = 1'b0;
        pop_commit  = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    level_next  = s_tdata[LEVEL_W-1:0];
                    data_next   = s_tdata[LEVEL_W +: STORE_W];
                    is_pop_next = (s_tuser == CMD_POP);
                    chunk_next  = CH_W'(NCHUNK - 1);
                    case (s_tuser)
                        CMD_PUSH: begin
                            state_next = S_PUSH;
                        end
                        CMD_POP, CMD_PEEK: begin
                            state_next = S_SCAN;
                        end
                        default: begin
                            status_next = ST_INVALID;
                            state_next  = S_RESP;
                        end
                    endcase
                end
            end
            S_PUSH: begin
                st_addr = {push_lvl, tail_reg[push_lvl]};
                if (!push_in_range) begin
                    res_status = ST_INVALID;
                end else if (push_full) begin
                    res_status = ST_OVERFLOW;
                end else begin
                    res_status = ST_OK;
                end
                if (out_free) begin
                    deliver     = 1'b1;
                    push_commit = (res_status == ST_OK);
                    st_ctrl.wr_en = push_commit;
                    state_next  = S_IDLE;
                end
            end
            S_SCAN: begin
                if (chunk_hit) begin
                    sel_next   = scan_lvl[LVL_W-1:0];
                    state_next = S_READ;
                end else if (chunk_reg == '0) begin
                    status_next = ST_EMPTY;
                    state_next  = S_RESP;
                end else begin
                    chunk_next = chunk_reg - 1'b1;
                end
            end
            S_READ: begin
                st_ctrl.rd_en = 1'b1;
                status_next   = ST_OK;
                state_next    = S_RESP;
            end
            S_RESP: begin
                if (status_reg == ST_OK) begin
                    res_item   = DATA_W'(st_rdata);
                    res_served = LEVEL_W'(sel_reg);
                end
                if (out_free) begin
                    deliver    = 1'b1;
                    pop_commit = is_pop_reg && (status_reg == ST_OK);
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            is_pop_reg <= 1'b0;
            chunk_reg  <= '0;
            sel_reg    <= '0;
            status_reg <= ST_OK;
        end else begin
            state_reg  <= state_next;
            is_pop_reg <= is_pop_next;
            chunk_reg  <= chunk_next;
            sel_reg    <= sel_next;
            status_reg <= status_next;
        end
        level_reg <= level_next;
        data_reg  <= data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_levels_reg <= CFG_W'(MAX_LEVELS);
        end else if (cfg_we && cfg_wdata != '0 && cfg_wdata <= CFG_W'(MAX_LEVELS)) begin
            num_levels_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_LEVELS; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            mask_reg <= '0;
        end else if (push_commit) begin
            tail_reg[push_lvl] <= (tail_reg[push_lvl] == PTR_W'(FIFO_DEPTH - 1))
                                ? '0 : tail_reg[push_lvl] + 1'b1;
            count_reg[push_lvl] <= count_reg[push_lvl] + 1'b1;
            mask_reg[push_lvl]  <= 1'b1;
        end else if (pop_commit) begin
            head_reg[sel_reg] <= (head_reg[sel_reg] == PTR_W'(FIFO_DEPTH - 1))
                               ? '0 : head_reg[sel_reg] + 1'b1;
            count_reg[sel_reg] <= count_reg[sel_reg] - 1'b1;
            // level drains on its last item
            if (count_reg[sel_reg] == CNT_W'(1)) begin
                mask_reg[sel_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (deliver) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (deliver) begin
            m_status_reg <= res_status;
            m_item_reg   <= res_item;
            m_served_reg <= res_served;
        end
    end

    mpf_store #(
        .ADDR_W (ADDR_W),
        .DEPTH  (MEM_DEPTH),
        .WORD_W (STORE_W)
    ) u_store (
        .aclk  (aclk),
        .ctrl  (st_ctrl),
        .addr  (st_addr),
        .wdata (data_reg),
        .rdata (st_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_served_reg, m_item_reg};
    assign m_tuser  = m_status_reg;

endmodule
